### rtl/u16u8_pkg.sv
// Package for the UTF-16 to UTF-8 line splitter.
// Holds the channel word types, the job type passed front to back, and code constants.
// No dependencies.
package u16u8_pkg;

	localparam int JOB_SLOTS = 8;
	localparam int JOB_CNT_W = $clog2(JOB_SLOTS + 1);
	localparam int JOB_IDX_W = $clog2(JOB_SLOTS);
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [1:0] KIND_BYTE = 2'd0;
	localparam logic [1:0] KIND_EOL  = 2'd1;
	localparam logic [1:0] KIND_EOS  = 2'd2;

	localparam logic [15:0] SURR_MASK = 16'hFC00;
	localparam logic [15:0] HIGH_SURR = 16'hD800;
	localparam logic [15:0] LOW_SURR  = 16'hDC00;
	localparam logic [15:0] CHAR_NUL  = 16'h0000;
	localparam logic [15:0] CHAR_CR   = 16'h000D;
	localparam logic [15:0] CHAR_LF   = 16'h000A;
	localparam logic [15:0] MAX_1B    = 16'h007F;
	localparam logic [15:0] MAX_2B    = 16'h07FF;
	localparam logic [16:0] SUPP_BASE = 17'h10000;

	localparam logic [7:0] REPL_B0 = 8'hEF;
	localparam logic [7:0] REPL_B1 = 8'hBF;
	localparam logic [7:0] REPL_B2 = 8'hBD;
	localparam logic [7:0] LEAD_2B = 8'hC0;
	localparam logic [7:0] LEAD_3B = 8'hE0;
	localparam logic [7:0] LEAD_4B = 8'hF0;
	localparam logic [7:0] CONT_B  = 8'h80;

	typedef struct packed {
		logic [15:0] code_unit;
		logic        final_unit;
	} unit_word_t;

	typedef struct packed {
		logic [1:0] result_kind;
		logic [7:0] byte_value;
		logic       run_last;
	} res_word_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] byte_value;
	} res_ent_t;

	typedef struct packed {
		res_ent_t [JOB_SLOTS-1:0] ent;
		logic [JOB_CNT_W-1:0]     count;
	} job_t;

endpackage

### rtl/u16u8_front.sv
// Front end: accepts code units, tracks surrogate/line/string state, builds a result job.
// Uses u16u8_pkg.
module u16u8_front
	import u16u8_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       unit_valid,
	output logic       unit_stall,
	input  unit_word_t unit_word,
	input  logic       q_full,
	output logic       q_push,
	output job_t       q_job
);

	logic [9:0] held_bits_q;
	logic       held_q;
	logic       line_q;
	logic       ended_q;

	logic [9:0] held_bits_n;
	logic       held_n;
	logic       line_n;
	logic       ended_n;
	job_t       job;
	logic       accept;

	logic [15:0] u;
	logic        fin;
	logic        is_high;
	logic        is_low;
	logic [20:0] cp;

	function automatic job_t put(job_t j, logic [1:0] k, logic [7:0] b);
		job_t r;
		r = j;
		r.ent[j.count[JOB_IDX_W-1:0]] = '{kind: k, byte_value: b};
		r.count = j.count + JOB_CNT_W'(1);
		return r;
	endfunction

	function automatic job_t put_repl(job_t j);
		job_t r;
		r = put(j, KIND_BYTE, REPL_B0);
		r = put(r, KIND_BYTE, REPL_B1);
		r = put(r, KIND_BYTE, REPL_B2);
		return r;
	endfunction

	assign u       = unit_word.code_unit;
	assign fin     = unit_word.final_unit;
	assign is_high = (u & SURR_MASK) == HIGH_SURR;
	assign is_low  = (u & SURR_MASK) == LOW_SURR;
	assign cp      = {4'd0, SUPP_BASE} + {1'b0, held_bits_q, u[9:0]};

	always_comb begin
		job         = '0;
		held_bits_n = held_bits_q;
		held_n      = held_q;
		line_n      = line_q;
		ended_n     = ended_q;
		if (ended_q) begin
			// swallowing units up to the final flag
			if (fin)
				ended_n = 1'b0;
		end else if (u == CHAR_NUL) begin
			if (held_q) begin
				job         = put_repl(job);
				line_n      = 1'b1;
				held_n      = 1'b0;
				held_bits_n = '0;
			end
			if (line_n)
				job = put(job, KIND_EOL, 8'h00);
			job     = put(job, KIND_EOS, 8'h00);
			line_n  = 1'b0;
			ended_n = !fin;
		end else begin
			if (held_q && is_low) begin
				job = put(job, KIND_BYTE, LEAD_4B | {5'd0, cp[20:18]});
				job = put(job, KIND_BYTE, CONT_B | {2'd0, cp[17:12]});
				job = put(job, KIND_BYTE, CONT_B | {2'd0, cp[11:6]});
				job = put(job, KIND_BYTE, CONT_B | {2'd0, cp[5:0]});
				line_n      = 1'b1;
				held_n      = 1'b0;
				held_bits_n = '0;
			end else begin
				if (held_q) begin
					// held high surrogate left unpaired
					job         = put_repl(job);
					line_n      = 1'b1;
					held_n      = 1'b0;
					held_bits_n = '0;
				end
				if (is_high) begin
					if (fin) begin
						job    = put_repl(job);
						line_n = 1'b1;
					end else begin
						held_n      = 1'b1;
						held_bits_n = u[9:0];
					end
				end else if (is_low) begin
					job    = put_repl(job);
					line_n = 1'b1;
				end else if (u == CHAR_CR) begin
					line_n = line_n;
				end else if (u == CHAR_LF) begin
					job    = put(job, KIND_EOL, 8'h00);
					line_n = 1'b0;
				end else if (u <= MAX_1B) begin
					job    = put(job, KIND_BYTE, u[7:0]);
					line_n = 1'b1;
				end else if (u <= MAX_2B) begin
					job    = put(job, KIND_BYTE, LEAD_2B | {3'd0, u[10:6]});
					job    = put(job, KIND_BYTE, CONT_B | {2'd0, u[5:0]});
					line_n = 1'b1;
				end else begin
					job    = put(job, KIND_BYTE, LEAD_3B | {4'd0, u[15:12]});
					job    = put(job, KIND_BYTE, CONT_B | {2'd0, u[11:6]});
					job    = put(job, KIND_BYTE, CONT_B | {2'd0, u[5:0]});
					line_n = 1'b1;
				end
			end
			if (fin) begin
				if (line_n)
					job = put(job, KIND_EOL, 8'h00);
				job    = put(job, KIND_EOS, 8'h00);
				line_n = 1'b0;
			end
		end
	end

	assign unit_stall = q_full;
	assign accept     = unit_valid && !q_full;
	assign q_push     = accept && (job.count != '0);
	assign q_job      = job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_bits_q <= '0;
			held_q      <= 1'b0;
			line_q      <= 1'b0;
			ended_q     <= 1'b0;
		end else if (accept) begin
			held_bits_q <= held_bits_n;
			held_q      <= held_n;
			line_q      <= line_n;
			ended_q     <= ended_n;
		end
	end

endmodule

### rtl/u16u8_fifo.sv
// Two-entry job queue between the front end and the byte sequencer.
// Uses u16u8_pkg.
module u16u8_fifo
	import u16u8_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic valid,
	output job_t head_job
);

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign full     = cnt_q == QCNT_W'(QDEPTH);
	assign valid    = cnt_q != '0;
	assign head_job = mem_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (do_push && !do_pop)
				cnt_q <= cnt_q + QCNT_W'(1);
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - QCNT_W'(1);
		end
	end

endmodule

### rtl/u16u8_back.sv
// Back end: walks one job a result at a time into the output register.
// Uses u16u8_pkg.
module u16u8_back
	import u16u8_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_valid,
	input  job_t      q_job,
	output logic      q_pop,
	output logic      res_valid,
	input  logic      res_stall,
	output res_word_t res_word
);

	job_t                 job_q;
	logic [JOB_IDX_W-1:0] idx_q;
	logic                 busy_q;
	logic                 res_valid_q;
	res_word_t            res_word_q;

	res_ent_t ent;
	logic     last;
	logic     advance;

	assign ent     = job_q.ent[idx_q];
	assign last    = {1'b0, idx_q} == (job_q.count - JOB_CNT_W'(1));
	assign advance = busy_q && (!res_valid_q || !res_stall);
	assign q_pop   = q_valid && (!busy_q || (advance && last));

	always_ff @(posedge clk) begin
		if (advance)
			res_word_q <= '{result_kind: ent.kind, byte_value: ent.byte_value, run_last: last};
		if (q_pop)
			job_q <= q_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			busy_q      <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (advance)
				res_valid_q <= 1'b1;
			else if (!res_stall)
				res_valid_q <= 1'b0;
			if (advance)
				idx_q <= idx_q + JOB_IDX_W'(1);
			if (advance && last)
				busy_q <= 1'b0;
			if (q_pop) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res_word  = res_word_q;

endmodule

### rtl/utf16_to_utf8_line_splitter.sv
// UTF-16 to UTF-8 line splitter, top level. Uses u16u8_pkg, u16u8_front, u16u8_fifo, u16u8_back.
// First result of a unit passes the queue entry, the back end's job register and the output register to res_word.
// Throughput: one result word per cycle from the back end while res_stall is low; a unit makes
// 1 to 8 results (3 for a typical BMP character); units with no result push no job.
// The front end takes a unit whenever the two-job queue has room.
// Reset (arst_n low) clears surrogate, line and string state, the queue and the output.
module utf16_to_utf8_line_splitter
	import u16u8_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       unit_valid,
	output logic       unit_stall,
	input  unit_word_t unit_word,
	output logic       res_valid,
	input  logic       res_stall,
	output res_word_t  res_word
);

	logic q_full;
	logic q_push;
	job_t q_push_job;
	logic q_pop;
	logic q_valid;
	job_t q_head_job;

	u16u8_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.unit_valid (unit_valid),
		.unit_stall (unit_stall),
		.unit_word  (unit_word),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_job      (q_push_job)
	);

	u16u8_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (q_push_job),
		.full     (q_full),
		.pop      (q_pop),
		.valid    (q_valid),
		.head_job (q_head_job)
	);

	u16u8_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_job     (q_head_job),
		.q_pop     (q_pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_word  (res_word)
	);

endmodule

### rtl/u16u8_chk.sv
// Port-level checker for the UTF-16 to UTF-8 line splitter, bound to the top level.
// Uses u16u8_pkg.
module u16u8_chk
	import u16u8_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_stall,
	input res_word_t  res_word
);

	// a stalled word holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_word))
		else $error("result word changed while stalled");

	a_marker_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_word.result_kind != KIND_BYTE |-> res_word.byte_value == 8'h00)
		else $error("marker word carries a nonzero byte");

	a_eos_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_word.result_kind == KIND_EOS |-> res_word.run_last)
		else $error("end of string is not the last word of its run");

	// a run never ends on a UTF-8 lead byte
	a_no_lead_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_word.result_kind == KIND_BYTE && res_word.run_last
			|-> res_word.byte_value[7:6] != 2'b11)
		else $error("run ends on a UTF-8 lead byte");

endmodule

bind utf16_to_utf8_line_splitter u16u8_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res_word  (res_word)
);
